// ----- hdl/sorted_key_queue_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_key_queue assertion macros
// concurrent assertion helpers shared by the sorted key queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_QUEUE_MACROS_SVH
`define SORTED_KEY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define SKQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SKQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKQ_ASSERT(lbl, prop, msg)
`define SKQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/skq_pkg.sv -----
// ----------------------------------------------------------------------------
// skq_pkg
// types, codes and sizes of the sorted key queue
// ----------------------------------------------------------------------------
package skq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] FN_PREPEND   = 3'd0;
    localparam logic [2:0] FN_APPEND    = 3'd1;
    localparam logic [2:0] FN_POP_FIRST = 3'd2;
    localparam logic [2:0] FN_INSERT    = 3'd3;
    localparam logic [2:0] FN_REMOVE    = 3'd4;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic signed [31:0] FRESH_KEY = 32'sd100;
    localparam logic signed [31:0] KEY_STEP  = 32'sd1;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        payload_in;
        logic signed [31:0] sort_key;
    } skq_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        payload_out;
        logic signed [31:0] key_out;
        logic               now_empty;
    } skq_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } skq_state_t;

    // which cells count as at or after the operation position
    typedef enum logic [1:0] {
        HIT_ALL,
        HIT_FREE,
        HIT_KEY
    } skq_hit_t;

    // which cell hands its entry to the controller
    typedef enum logic [1:0] {
        PICK_NONE,
        PICK_POS,
        PICK_MATCH,
        PICK_TAIL
    } skq_pick_mode_t;

    typedef struct packed {
        logic               eval_en;
        skq_hit_t           hit;
        skq_pick_mode_t     pick;
        logic               ins;
        logic               rem;
        logic signed [31:0] skey;
        logic signed [31:0] new_key;
        logic [31:0]        payload;
    } skq_ctl_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } skq_ent_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } skq_pick_t;

endpackage

// ----- hdl/sorted_key_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_key_queue
// bounded queue of (key, payload) entries held in ascending key order
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 word
// command   in         start & !busy             cmd  (func, payload_in, sort_key)
// result    out        done, one cycle, no stall rsp  (status, payload_out, key_out,
//                                                      now_empty)
//
// every command passes through an evaluate cycle, in which each cell compares
// its key and the position ripples down the cell chain, then an apply cycle in
// which the cells shift one place; the next word is taken in the apply cycle
// the result word shows on rsp with done for one cycle right after the apply
// edge; it cannot be held off
// reset clears the entry count and all cell valid bits; no clearing pass
//
module sorted_key_queue
    import skq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  skq_cmd_t cmd,
    output logic     done,
    output skq_rsp_t rsp
);

`include "sorted_key_queue_macros.svh"

    skq_state_t  state_reg, state_next;
    skq_cmd_t    cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    skq_pick_t   pick_reg, pick_next;
    skq_rsp_t    rsp_reg, rsp_next;
    logic        done_reg, done_next;
    skq_ctl_t    ctl;
    logic        accept;
    logic        full;
    logic        empty;

    // cell chain wiring
    skq_ent_t    ent_w   [DEPTH];
    skq_ent_t    left_w  [DEPTH];
    skq_ent_t    right_w [DEPTH];
    logic        seen_w  [DEPTH+1];
    logic        pos_w   [DEPTH+1];
    skq_pick_t   pick_w  [DEPTH+1];
    logic [DEPTH-1:0] valid_vec;

    assign seen_w[0]   = 1'b0;
    assign pos_w[DEPTH] = 1'b0;
    assign pick_w[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_w[i] = '0;
        end
        else
        begin : g_mid_l
            assign left_w[i] = ent_w[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w[i] = '0;
        end
        else
        begin : g_mid_r
            assign right_w[i] = ent_w[i+1];
        end
        assign valid_vec[i] = ent_w[i].valid;

        skq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left      (left_w[i]),
            .right     (right_w[i]),
            .seen_in   (seen_w[i]),
            .seen_out  (seen_w[i+1]),
            .pos_right (pos_w[i+1]),
            .pos_out   (pos_w[i]),
            .pick_in   (pick_w[i]),
            .pick_out  (pick_w[i+1]),
            .ent       (ent_w[i])
        );
    end

    assign busy   = (state_reg == S_EVAL);
    assign accept = start & ~busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        pick_next  = pick_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;

        ctl         = '0;
        ctl.hit     = HIT_ALL;
        ctl.pick    = PICK_NONE;
        ctl.skey    = cmd_reg.sort_key;
        ctl.payload = cmd_reg.payload_in;

        // the cells see the search mode in eval and apply alike; it only matters in eval
        unique case (cmd_reg.func)
            FN_PREPEND:
            begin
                ctl.hit  = HIT_ALL;
                ctl.pick = PICK_POS;
            end
            FN_APPEND:
            begin
                ctl.hit  = HIT_FREE;
                ctl.pick = PICK_TAIL;
            end
            FN_POP_FIRST:
            begin
                ctl.hit  = HIT_ALL;
                ctl.pick = PICK_POS;
            end
            FN_INSERT:
            begin
                ctl.hit  = HIT_KEY;
                ctl.pick = PICK_NONE;
            end
            FN_REMOVE:
            begin
                ctl.hit  = HIT_KEY;
                ctl.pick = PICK_MATCH;
            end
            default:
            begin
                ctl.hit  = HIT_ALL;
                ctl.pick = PICK_NONE;
            end
        endcase

        // new key for head, tail or sorted insert
        unique case (cmd_reg.func)
            FN_PREPEND: ctl.new_key = empty ? FRESH_KEY : pick_reg.key - KEY_STEP;
            FN_APPEND:  ctl.new_key = empty ? FRESH_KEY : pick_reg.key + KEY_STEP;
            default:    ctl.new_key = cmd_reg.sort_key;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval_en = 1'b1;
                pick_next   = pick_w[DEPTH];
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                done_next           = 1'b1;
                rsp_next.status      = STAT_DONE;
                rsp_next.payload_out = '0;
                rsp_next.key_out     = '0;
                unique case (cmd_reg.func)
                    FN_PREPEND, FN_APPEND, FN_INSERT:
                    begin
                        if (full)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            ctl.ins          = 1'b1;
                            rsp_next.key_out = ctl.new_key;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    FN_POP_FIRST, FN_REMOVE:
                    begin
                        if (!pick_reg.found)
                        begin
                            rsp_next.status = STAT_MISS;
                        end
                        else
                        begin
                            ctl.rem              = 1'b1;
                            rsp_next.key_out     = pick_reg.key;
                            rsp_next.payload_out = pick_reg.payload;
                            count_next           = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        rsp_next.status = STAT_DONE;
                    end
                endcase
                rsp_next.now_empty = (count_next == '0);
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pick_reg <= pick_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // entry count tracks the occupied cells
    `SKQ_ASSERT(a_count_cells, $countones(valid_vec) == int'(count_reg), "count mismatch")
    // no result word while reset is held
    `SKQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !done, "done during reset")
    // a result word follows an apply cycle
    `SKQ_ASSERT(a_done_after_apply, done |-> $past(state_reg == S_APPLY), "stray done")
    // evaluate always leads straight to apply
    `SKQ_ASSERT(a_eval_apply, state_reg == S_EVAL |=> state_reg == S_APPLY, "eval not followed by apply")
    // a rejected insert only happens with every cell occupied
    `SKQ_ASSERT(a_full_reject, done && rsp.status == STAT_FULL |-> count_reg == CNT_W'(DEPTH), "false full")
    // the empty flag agrees with the count
    `SKQ_ASSERT(a_empty_flag, done |-> rsp.now_empty == (count_reg == '0), "empty flag wrong")

endmodule

// ----- hdl/skq_cell.sv -----
// ----------------------------------------------------------------------------
// skq_cell
// one queue slot: compares against the search key and shifts with neighbors
// ----------------------------------------------------------------------------
module skq_cell
    import skq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  skq_ctl_t  ctl,
    input  skq_ent_t  left,
    input  skq_ent_t  right,
    input  logic      seen_in,
    output logic      seen_out,
    input  logic      pos_right,
    output logic      pos_out,
    input  skq_pick_t pick_in,
    output skq_pick_t pick_out,
    output skq_ent_t  ent
);

    logic               valid_reg, valid_next;
    logic signed [31:0] key_reg, key_next;
    logic [31:0]        payload_reg, payload_next;
    logic               after_reg, after_next;
    logic               pos_reg, pos_next;
    logic               less;
    logic               hit;
    logic               is_pos;
    logic               take;

    always_comb
    begin
        less = key_reg < ctl.skey;
        unique case (ctl.hit)
            HIT_ALL:  hit = 1'b1;
            HIT_FREE: hit = ~valid_reg;
            HIT_KEY:  hit = ~valid_reg | ~less;
            default:  hit = 1'b1;
        endcase
        is_pos   = hit & ~seen_in;
        seen_out = seen_in | hit;
        pos_out  = is_pos;

        unique case (ctl.pick)
            PICK_NONE:  take = 1'b0;
            PICK_POS:   take = is_pos & valid_reg;
            PICK_MATCH: take = is_pos & valid_reg & (key_reg == ctl.skey);
            PICK_TAIL:  take = valid_reg & pos_right;
            default:    take = 1'b0;
        endcase
        pick_out.found   = pick_in.found | take;
        pick_out.key     = pick_in.key | (take ? key_reg : '0);
        pick_out.payload = pick_in.payload | (take ? payload_reg : '0);

        after_next = ctl.eval_en ? seen_in : after_reg;
        pos_next   = ctl.eval_en ? is_pos : pos_reg;

        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        // insert shifts toward the tail, remove shifts toward the head
        if (ctl.ins && after_reg)
        begin
            valid_next   = left.valid;
            key_next     = left.key;
            payload_next = left.payload;
        end
        else if (ctl.ins && pos_reg)
        begin
            valid_next   = 1'b1;
            key_next     = ctl.new_key;
            payload_next = ctl.payload;
        end
        else if (ctl.rem && (after_reg || pos_reg))
        begin
            valid_next   = right.valid;
            key_next     = right.key;
            payload_next = right.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            after_reg <= 1'b0;
            pos_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign ent.valid   = valid_reg;
    assign ent.key     = key_reg;
    assign ent.payload = payload_reg;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_queue testbench
// drives command words through the start/busy handshake with random gaps,
// mirrors the queue in a local model and checks every result word on done
// ----------------------------------------------------------------------------
module testbench;
    import skq_pkg::*;

    // func codes the block treats as no operation
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_ITEMS = 1025;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no word moving either way
    localparam int DRAIN_CYCLES = 8;      // a little margin after the last result word
    localparam int MAX_PRINTED  = 40;     // keep the log short on a bad run

    // fill / drain / balanced stretches of random traffic
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    skq_cmd_t cmd   = '0;
    logic     done;
    skq_rsp_t rsp;

    sorted_key_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    // 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // local copy of the queue, head at index 0
    // ------------------------------------------------------------------
    logic signed [31:0] model_keys [DEPTH];
    logic [31:0]        model_pays [DEPTH];
    int                 model_len = 0;

    skq_cmd_t pending_cmds [$];   // words still to be driven
    skq_rsp_t expected_rsp [$];   // results owed by the block, oldest first

    int cmds_sent   = 0;
    int cmds_taken  = 0;
    int gap_left    = 0;
    int calm_left   = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int total_items = 0;
    int roll;
    skq_rsp_t want;

    // apply one command to the local queue and return the result word it owes
    function automatic skq_rsp_t queue_apply(input skq_cmd_t c);
        skq_rsp_t           r;
        logic signed [31:0] k;
        int                 pos;
        int                 i;
        r   = '0;
        k   = '0;
        pos = 0;
        r.status = STAT_DONE;
        case (c.func)
            FN_PREPEND, FN_APPEND, FN_INSERT:
            begin
                if (model_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (c.func == FN_PREPEND)
                    begin
                        // head minus one, wraps past the minimum
                        k   = (model_len == 0) ? FRESH_KEY : model_keys[0] - KEY_STEP;
                        pos = 0;
                    end
                    else if (c.func == FN_APPEND)
                    begin
                        k   = (model_len == 0) ? FRESH_KEY
                                               : model_keys[model_len - 1] + KEY_STEP;
                        pos = model_len;
                    end
                    else
                    begin
                        // before the first entry whose key is not less
                        k = c.sort_key;
                        while (pos < model_len && model_keys[pos] < k)
                            pos++;
                    end
                    for (i = model_len; i > pos; i--)
                    begin
                        model_keys[i] = model_keys[i - 1];
                        model_pays[i] = model_pays[i - 1];
                    end
                    model_keys[pos] = k;
                    model_pays[pos] = c.payload_in;
                    model_len++;
                    r.key_out = k;
                end
            end
            FN_POP_FIRST, FN_REMOVE:
            begin
                if (c.func == FN_REMOVE)
                    while (pos < model_len && model_keys[pos] < c.sort_key)
                        pos++;
                if (pos >= model_len
                    || (c.func == FN_REMOVE && model_keys[pos] != c.sort_key))
                    r.status = STAT_MISS;
                else
                begin
                    r.key_out     = model_keys[pos];
                    r.payload_out = model_pays[pos];
                    for (i = pos; i + 1 < model_len; i++)
                    begin
                        model_keys[i] = model_keys[i + 1];
                        model_pays[i] = model_pays[i + 1];
                    end
                    model_len--;
                end
            end
            default:
                ;
        endcase
        r.now_empty = (model_len == 0);
        return r;
    endfunction

    task automatic queue_cmd(input logic [2:0] f, input logic [31:0] pay,
                             input logic signed [31:0] key);
        skq_cmd_t c;
        c.func       = f;
        c.payload_in = pay;
        c.sort_key   = key;
        pending_cmds.push_back(c);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp_val);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch %s: got %h, want %h at %0t", what, got, exp_val, $realtime);
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed opening, then random stretches that fill and drain
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        mix_t               mix;
        int                 mix_left;
        int                 n;
        int                 grow;
        int                 kroll;
        logic [2:0]         f;
        logic signed [31:0] key;
        mix      = MIX_EVEN;
        mix_left = 0;

        // empty queue: both removes miss
        queue_cmd(FN_POP_FIRST, 32'h0, 32'sd0);
        queue_cmd(FN_REMOVE, 32'hffff_ffff, 32'sd100);
        // fresh key on empty, then head-1 / tail+1
        queue_cmd(FN_PREPEND, 32'h1111_1111, 32'sd0);
        queue_cmd(FN_APPEND, 32'h2222_2222, 32'sd0);
        queue_cmd(FN_PREPEND, 32'h3333_3333, 32'sd0);
        // largest key, then tail+1 wraps to the smallest
        queue_cmd(FN_INSERT, 32'hffff_ffff, KEY_MAX);
        queue_cmd(FN_APPEND, 32'h0000_0000, KEY_MIN);
        // smallest key lands at the head, then head-1 wraps to the largest
        queue_cmd(FN_INSERT, 32'h8000_0001, KEY_MIN);
        queue_cmd(FN_PREPEND, 32'h7fff_fffe, KEY_MAX);
        // sorted remove: the wrapped largest key at the head stops both searches
        queue_cmd(FN_REMOVE, 32'h0, 32'sd100);
        queue_cmd(FN_REMOVE, 32'h0, 32'sd55);
        // spare codes do nothing
        for (n = FN_SPARE_LO; n <= FN_SPARE_HI; n++)
            queue_cmd(3'(n), 32'hdead_beef, -32'sd1);
        // seven entries are held here: fill to the brim, then every insert kind is turned away
        for (n = 0; n < DEPTH - 7; n++)
            queue_cmd(FN_APPEND, $urandom, 32'sd0);
        queue_cmd(FN_PREPEND, 32'h5555_5555, 32'sd0);
        queue_cmd(FN_APPEND, 32'haaaa_aaaa, 32'sd0);
        queue_cmd(FN_INSERT, 32'h1234_5678, 32'sd0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mix_left == 0)
            begin
                mix      = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            grow  = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
            roll  = $urandom_range(0, 99);
            kroll = $urandom_range(0, 99);
            if (roll < 3)
                f = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
            else if (roll < 3 + grow)
                case ($urandom_range(0, 3))
                    0, 1:    f = FN_INSERT;
                    2:       f = FN_APPEND;
                    default: f = FN_PREPEND;
                endcase
            else
                f = ($urandom_range(0, 4) < 3) ? FN_REMOVE : FN_POP_FIRST;
            // narrow band near the fresh key so sorted removes often hit
            if (kroll < 70)
                key = 32'($urandom_range(88, 112));
            else if (kroll < 90)
                key = $urandom;
            else
                case ($urandom_range(0, 3))
                    0:       key = KEY_MIN;
                    1:       key = KEY_MAX;
                    2:       key = -32'sd1;
                    default: key = 32'sd0;
                endcase
            queue_cmd(f, $urandom, key);
        end
        total_items = pending_cmds.size();

        // async reset held from the start, released away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (cmds_taken == total_items && expected_rsp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[sorted_key_queue] OK");
        else
            $display("[sorted_key_queue] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: one word on cmd while start is high, new words at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && cmds_taken != cmds_sent)
                ;   // word still waiting for !busy, hold it
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd   <= pending_cmds.pop_front();
                start <= 1'b1;
                cmds_sent++;
                // gap after this word: mostly none or short, a few long,
                // with occasional stretches of back to back words
                if (calm_left > 0)
                    calm_left--;
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        calm_left = $urandom_range(20, 60);
                    else if (roll < 50)
                        gap_left = 0;
                    else if (roll < 90)
                        gap_left = $urandom_range(1, 3);
                    else
                        gap_left = $urandom_range(8, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // word taken by the block: predict its result right away
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_rsp.push_back(queue_apply(cmd));
            cmds_taken++;
        end
    end

    // ------------------------------------------------------------------
    // monitor: result word is valid for the one cycle done is high
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
                report("result word with nothing owed", 32'(rsp.status), 32'h0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                    report("status", 32'(rsp.status), 32'(want.status));
                if (rsp.payload_out !== want.payload_out)
                    report("payload_out", rsp.payload_out, want.payload_out);
                if (rsp.key_out !== want.key_out)
                    report("key_out", rsp.key_out, want.key_out);
                if (rsp.now_empty !== want.now_empty)
                    report("now_empty", 32'(rsp.now_empty), 32'(want.now_empty));
            end
        end
    end

    // watchdog: nothing moving in either direction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[sorted_key_queue] ERROR");
                $finish;
            end
        end
    end

endmodule
